### rtl/gbg_pkg.sv
// shared constants, types and state encodings of the gaussian blur block
package gbg_pkg;

  localparam int MAX_WIDTH        = 1024;
  localparam int MAX_RADIUS       = 3;
  localparam int WEIGHT_FRAC_BITS = 15;

  localparam int WIN_SIDE  = 2 * MAX_RADIUS + 1;
  localparam int LINE_ROWS = 2 * MAX_RADIUS;

  localparam int PIX_W   = 8;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 12;
  localparam int FW_W    = 11;
  localparam int RAD_W   = 2;
  localparam int WGT_W   = 16;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;
  localparam int WIN_W   = $clog2(WIN_SIDE);
  localparam int LINE_W  = LINE_ROWS * PIX_W;

  // one kernel row: WIN_SIDE products of weight x pixel
  localparam int ROWACC_W = WGT_W + PIX_W + 3;
  localparam int PROD_W   = ROWACC_W + WGT_W;
  localparam int SUM_W    = PROD_W + 3;
  localparam int FRAC2    = 2 * WEIGHT_FRAC_BITS;

  typedef enum logic [IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_RADIUS = 3'd2,
    REG_W0     = 3'd3,
    REG_W1     = 3'd4,
    REG_W2     = 3'd5,
    REG_W3     = 3'd6
  } gbg_reg_t;

  typedef enum logic {
    T_IDLE,
    T_READ
  } gbg_top_state_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MAC,
    F_RMUL,
    F_RADD,
    F_ROUND
  } gbg_flt_state_t;

  // handed from the line store control to the filter
  typedef struct packed {
    logic             load;
    logic             run;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } gbg_job_t;

endpackage

### rtl/gbg_if.sv
// stream interfaces for pixel words and result words
interface gbg_in_if
  import gbg_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  logic             frame_start;

  modport source (output valid, output pixel_in, output frame_start, input ready);
  modport sink (input valid, input pixel_in, input frame_start, output ready);
endinterface

interface gbg_out_if
  import gbg_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;
  logic [PIX_W-1:0] out_value;
  logic             frame_last;

  modport source (output valid, output out_col, output out_row, output out_value,
                  output frame_last, input ready);
  modport sink (input valid, input out_col, input out_row, input out_value,
                input frame_last, output ready);
endinterface

### rtl/gbg_ram.sv
// generic simple dual port ram with registered read
module gbg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/gbg_filt.sv
// window registers, serial multiply-accumulate and result register
module gbg_filt
  import gbg_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  gbg_job_t                   job,
  input  logic [LINE_W-1:0]          col_data,
  input  logic [PIX_W-1:0]           pix,
  input  logic [RAD_W-1:0]           radius,
  input  logic [3:0][WGT_W-1:0]      wgt,
  output logic                       busy,
  gbg_out_if.source                  out_ch
);
  gbg_flt_state_t state, state_next;

  logic [PIX_W-1:0]    win [WIN_SIDE][WIN_SIDE];
  logic [WIN_W-1:0]    a_cnt;
  logic [WIN_W-1:0]    b_cnt;
  logic [ROWACC_W-1:0] rowacc;
  logic [PROD_W-1:0]   prod;
  logic [SUM_W-1:0]    sum;
  logic [COL_W-1:0]    col_q;
  logic [ROW_W-1:0]    row_q;
  logic                last_q;

  logic mac_en, rmul_en, radd_en, round_en;
  logic [WGT_W-1:0] wx, wy;
  logic [SUM_W-1:0] rnd;
  logic [WIN_W-1:0] kbase;
  logic             in_kern;

  // weight of a window position; zero outside the active kernel
  function automatic logic [WGT_W-1:0] wsel(input logic [WIN_W-1:0] pos,
                                            input logic [RAD_W-1:0] r,
                                            input logic [3:0][WGT_W-1:0] w);
    logic [WIN_W-1:0] base;
    logic [WIN_W-1:0] ctr;
    logic [WIN_W-1:0] off;
    base = WIN_W'(WIN_SIDE - 1) - WIN_W'({r, 1'b0});
    ctr  = WIN_W'(WIN_SIDE - 1) - WIN_W'(r);
    off  = (pos >= ctr) ? pos - ctr : ctr - pos;
    if (pos < base) begin
      return '0;
    end
    return w[off[1:0]];
  endfunction

  assign wx  = wsel(b_cnt, radius, wgt);
  assign wy  = wsel(a_cnt, radius, wgt);
  assign rnd = sum + (SUM_W'(1) << (FRAC2 - 1));

  // only window cells inside the active kernel reach the accumulator
  assign kbase   = WIN_W'(WIN_SIDE - 1) - WIN_W'({radius, 1'b0});
  assign in_kern = (a_cnt >= kbase) && (b_cnt >= kbase);

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE:  if (job.load && job.run) state_next = F_MAC;
      F_MAC:   if (b_cnt == WIN_W'(WIN_SIDE - 1)) state_next = F_RMUL;
      F_RMUL:  state_next = F_RADD;
      F_RADD:  state_next = (a_cnt == WIN_W'(WIN_SIDE - 1)) ? F_ROUND : F_MAC;
      F_ROUND: if (!out_ch.valid || out_ch.ready) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    mac_en   = (state == F_MAC);
    rmul_en  = (state == F_RMUL);
    radd_en  = (state == F_RADD);
    round_en = (state == F_ROUND) && (!out_ch.valid || out_ch.ready);
    busy     = (state != F_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // window: shift in a column on load, rotate in place while summing
  always_ff @(posedge clk) begin
    if (job.load) begin
      for (int i = 0; i < WIN_SIDE; i++) begin
        for (int j = 0; j < WIN_SIDE - 1; j++) begin
          win[i][j] <= win[i][j+1];
        end
      end
      for (int i = 0; i < LINE_ROWS; i++) begin
        win[i][WIN_SIDE-1] <= col_data[i*PIX_W +: PIX_W];
      end
      win[LINE_ROWS][WIN_SIDE-1] <= pix;
    end else if (mac_en) begin
      for (int i = 0; i < WIN_SIDE; i++) begin
        for (int j = 0; j < WIN_SIDE; j++) begin
          win[i][j] <= win[i][(j + 1) % WIN_SIDE];
        end
      end
    end else if (rmul_en) begin
      for (int i = 0; i < WIN_SIDE; i++) begin
        for (int j = 0; j < WIN_SIDE; j++) begin
          win[i][j] <= win[(i + 1) % WIN_SIDE][j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job.load) begin
      col_q  <= job.col;
      row_q  <= job.row;
      last_q <= job.last;
      a_cnt  <= '0;
      b_cnt  <= '0;
      rowacc <= '0;
      sum    <= '0;
    end else if (mac_en) begin
      if (in_kern) begin
        rowacc <= rowacc + ROWACC_W'(wx * win[0][0]);
      end
      b_cnt  <= b_cnt + 1'b1;
    end else if (rmul_en) begin
      prod <= PROD_W'(rowacc * wy);
    end else if (radd_en) begin
      sum    <= sum + SUM_W'(prod);
      rowacc <= '0;
      b_cnt  <= '0;
      a_cnt  <= a_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (round_en) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (round_en) begin
      out_ch.out_col    <= col_q;
      out_ch.out_row    <= row_q;
      out_ch.frame_last <= last_q;
      out_ch.out_value  <= (|rnd[SUM_W-1:FRAC2+PIX_W]) ? '1 : rnd[FRAC2 +: PIX_W];
    end
  end
endmodule

### rtl/gaussian_blur_gray8.sv
// top level of the streaming 7x7 gaussian blur for 8-bit gray pixels
//
//  channel  dir  words                                       handshake
//  in_ch    in   pixel_in, frame_start                       valid/ready
//  out_ch   out  out_col, out_row, out_value, frame_last     valid/ready
//  cfg      in   cfg_we, cfg_index, cfg_data                 write on cfg_we
//
//  an input word is taken while its line store column is read; the column
//  is written back in the next cycle; for an interior pixel the filter then
//  runs MAC, one multiply-accumulate a cycle, then RMUL and RADD per row
//  a result word sits in the output register; the filter only waits there
//  when the previous result has not been taken
//  reset clears counters and handshake state and loads the default
//  configuration; line store and window contents stay undefined until written
module gaussian_blur_gray8
  import gbg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  gbg_in_if.sink           in_ch,
  gbg_out_if.source        out_ch
);
  // configuration registers
  logic [FW_W-1:0]          frame_width;
  logic [ROW_W-1:0]         frame_height;
  logic [RAD_W-1:0]         kernel_radius;
  logic [3:0][WGT_W-1:0]    wgt;

  // position counters
  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;

  gbg_top_state_t state, state_next;

  logic             accept;
  logic             flt_busy;
  logic [FW_W-1:0]  w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [2:0]       side;
  logic [2:0]       twice_r;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic [FW_W-1:0]  col_inc;
  logic [ROW_W:0]   row_inc;
  logic             produce;

  logic [COL_W-1:0] col_q;
  logic [PIX_W-1:0] pix_q;
  logic             run_q;
  logic [COL_W-1:0] ocol_q;
  logic [ROW_W-1:0] orow_q;
  logic             last_q;

  logic [LINE_W-1:0] line_rd;
  logic              line_we;
  gbg_job_t          job;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= FW_W'(640);
      frame_height  <= ROW_W'(480);
      kernel_radius <= RAD_W'(2);
      wgt[0]        <= WGT_W'(32768);
      wgt[1]        <= WGT_W'(16384);
      wgt[2]        <= WGT_W'(4096);
      wgt[3]        <= WGT_W'(512);
    end else if (cfg_we) begin
      case (gbg_reg_t'(cfg_index))
        REG_WIDTH:  frame_width   <= cfg_data[FW_W-1:0];
        REG_HEIGHT: frame_height  <= cfg_data[ROW_W-1:0];
        REG_RADIUS: kernel_radius <= cfg_data[RAD_W-1:0];
        REG_W0:     wgt[0]        <= cfg_data;
        REG_W1:     wgt[1]        <= cfg_data;
        REG_W2:     wgt[2]        <= cfg_data;
        REG_W3:     wgt[3]        <= cfg_data;
        default:    ;
      endcase
    end
  end

  // effective geometry: zero acts as one, width saturates at the line length
  always_comb begin
    if (frame_width == '0) begin
      w_eff = FW_W'(1);
    end else if (frame_width > FW_W'(MAX_WIDTH)) begin
      w_eff = FW_W'(MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    h_eff   = (frame_height == '0) ? ROW_W'(1) : frame_height;
    twice_r = {kernel_radius, 1'b0};
    side    = twice_r + 3'd1;
  end

  // coordinates of the word being taken; frame_start restarts the frame
  always_comb begin
    cur_col = (in_ch.frame_start || FW_W'(col_count) >= w_eff) ? '0 : col_count;
    cur_row = (in_ch.frame_start || row_count >= h_eff) ? '0 : row_count;
    col_inc = FW_W'(cur_col) + 1'b1;
    row_inc = {1'b0, cur_row} + 1'b1;
    produce = (w_eff > FW_W'(side)) && (h_eff > ROW_W'(side)) &&
              (cur_col >= COL_W'(twice_r)) && (cur_row >= ROW_W'(twice_r));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (col_inc >= w_eff) begin
        col_count <= '0;
        row_count <= (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_count <= col_inc[COL_W-1:0];
        row_count <= cur_row;
      end
    end
  end

  // word captured for the read-modify-write of its line store column
  always_ff @(posedge clk) begin
    if (accept) begin
      col_q  <= cur_col;
      pix_q  <= in_ch.pixel_in;
      run_q  <= produce;
      ocol_q <= cur_col - COL_W'(kernel_radius);
      orow_q <= cur_row - ROW_W'(kernel_radius);
      last_q <= (FW_W'(cur_col) == w_eff - 1'b1) && (cur_row == h_eff - 1'b1);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      T_IDLE:  if (accept) state_next = T_READ;
      T_READ:  state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state == T_IDLE) && !flt_busy;
    line_we     = (state == T_READ);
    job.load    = (state == T_READ);
    job.run     = run_q;
    job.col     = ocol_q;
    job.row     = orow_q;
    job.last    = last_q;
  end

  assign accept = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // one entry per column holds the last six rows; oldest row in the low byte
  gbg_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (col_q),
    .wdata ({pix_q, line_rd[LINE_W-1:PIX_W]}),
    .raddr (cur_col),
    .rdata (line_rd)
  );

  gbg_filt u_filt (
    .clk      (clk),
    .rst      (rst),
    .job      (job),
    .col_data (line_rd),
    .pix      (pix_q),
    .radius   (kernel_radius),
    .wgt      (wgt),
    .busy     (flt_busy),
    .out_ch   (out_ch)
  );
endmodule

### rtl/gbg_checker.sv
// port-level checks of the gaussian blur block, bound to the top level
module gbg_checker
  import gbg_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] out_value,
  input logic [COL_W-1:0] out_col
);
  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_value) && $stable(out_col))
    else $error("result word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("second word taken during line store update");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !$rose(out_valid))
    else $error("result appeared before filtering could finish");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind gaussian_blur_gray8 gbg_checker u_gbg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.out_value),
  .out_col   (out_ch.out_col)
);
